### hw/rtl/hcs_pkg.sv
`timescale 1ns / 1ps

package hcs_pkg;

    // Matrix size range and default
    localparam int MATRIX_SIZE_DEF = 3;
    localparam int MATRIX_SIZE_MAX = 3;

    // Field and register widths
    localparam int IDX_W       = 6;
    localparam int CHAR_W      = 8;
    localparam int KEY_W       = 54;
    localparam int KEY_ENTRIES = 9;
    localparam int KEY_SEL_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_W     = 2;

    // Alphabet size and modular reduction constants
    localparam int ALPHA_LEN   = 41;
    localparam int ACC_W       = 13;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 13;
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + ALPHA_LEN - 1) / ALPHA_LEN;
    localparam int QUO_W       = 8;

    // Queue depths (powers of two)
    localparam int JOB_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH = 4;

    // ASCII codes used by the alphabet mapping
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_QUEST   = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    // Alphabet indices of the symbol groups
    localparam logic [IDX_W-1:0] IDX_SPACE       = 6'd0;
    localparam logic [IDX_W-1:0] IDX_LETTER_BASE = 6'd1;
    localparam logic [IDX_W-1:0] IDX_LETTER_LAST = 6'd26;
    localparam logic [IDX_W-1:0] IDX_DIGIT_BASE  = 6'd27;
    localparam logic [IDX_W-1:0] IDX_DIGIT_LAST  = 6'd36;
    localparam logic [IDX_W-1:0] IDX_DOT         = 6'd37;
    localparam logic [IDX_W-1:0] IDX_QUEST       = 6'd38;
    localparam logic [IDX_W-1:0] IDX_COMMA       = 6'd39;
    localparam logic [IDX_W-1:0] IDX_DASH        = 6'd40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION   = 2'd0,
        CFG_ENCRYPT_KEY = 2'd1,
        CFG_DECRYPT_KEY = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } t_dir;

    typedef enum logic {
        MODE_DATA = 1'b0,
        MODE_END  = 1'b1
    } t_mode;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] data_char;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              group_last;
        logic              message_end;
    } t_out_item;

    // Flags that travel with a group from front to back
    typedef struct packed {
        logic dir;
        logic at_end;
    } t_job_flags;

    // Flags that travel with one row through the back pipeline
    typedef struct packed {
        logic group_last;
        logic message_end;
    } t_row_flags;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_lookup;

    typedef logic [KEY_ENTRIES-1:0][IDX_W-1:0] t_key;

    // Fold a lowercase letter to upper case
    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] res;
        res = ch;
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            res = ch - CASE_DIFF;
        end
        return res;
    endfunction

    // Map an ASCII code to its alphabet index
    function automatic t_lookup char_to_index(input logic [CHAR_W-1:0] ch);
        t_lookup res;
        res.valid = 1'b1;
        res.idx   = IDX_SPACE;
        if (ch == CH_SPACE) begin
            res.idx = IDX_SPACE;
        end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            res.idx = IDX_W'(ch - CH_UPPER_A) + IDX_LETTER_BASE;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            res.idx = IDX_W'(ch - CH_DIGIT_0) + IDX_DIGIT_BASE;
        end else if (ch == CH_DOT) begin
            res.idx = IDX_DOT;
        end else if (ch == CH_QUEST) begin
            res.idx = IDX_QUEST;
        end else if (ch == CH_COMMA) begin
            res.idx = IDX_COMMA;
        end else if (ch == CH_DASH) begin
            res.idx = IDX_DASH;
        end else begin
            res.valid = 1'b0;
        end
        return res;
    endfunction

    // Map an alphabet index back to its ASCII code
    function automatic logic [CHAR_W-1:0] index_to_char(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] res;
        if (idx == IDX_SPACE) begin
            res = CH_SPACE;
        end else if (idx <= IDX_LETTER_LAST) begin
            res = CH_UPPER_A + CHAR_W'(idx - IDX_LETTER_BASE);
        end else if (idx <= IDX_DIGIT_LAST) begin
            res = CH_DIGIT_0 + CHAR_W'(idx - IDX_DIGIT_BASE);
        end else if (idx == IDX_DOT) begin
            res = CH_DOT;
        end else if (idx == IDX_QUEST) begin
            res = CH_QUEST;
        end else if (idx == IDX_COMMA) begin
            res = CH_COMMA;
        end else if (idx == IDX_DASH) begin
            res = CH_DASH;
        end else begin
            res = CH_SPACE;
        end
        return res;
    endfunction

endpackage

### hw/rtl/hcs_fifo.sv
`timescale 1ns / 1ps

// Small register queue; Depth must be a power of two
module hcs_fifo #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [Width-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [Width-1:0]           o_rdata,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(Depth+1)-1:0] o_count
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CntW'(Depth));
    assign o_count   = r_count;
    assign o_rdata   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Store the entry at the write pointer
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/hcs_front.sv
`timescale 1ns / 1ps

// Front: map characters, collect groups, hand full and end-padded groups to the job queue
module hcs_front #(
    parameter int MatrixSize = hcs_pkg::MATRIX_SIZE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  hcs_pkg::t_in_item                      i_item,
    input  logic                                   i_direction,
    input  logic                                   i_job_full,
    output logic                                   o_full,
    output logic                                   o_job_push,
    output logic [MatrixSize*hcs_pkg::IDX_W-1:0]   o_job_idx,
    output hcs_pkg::t_job_flags                    o_job_flags
);

    localparam int BufDepth = MatrixSize - 1;
    localparam int IdxW     = hcs_pkg::IDX_W;
    localparam int CountW   = hcs_pkg::COUNT_W;

    logic [CountW-1:0]                r_count;
    logic [CountW-1:0]                n_count;
    logic [BufDepth-1:0][IdxW-1:0]    r_buf;
    logic                             w_accept;
    logic                             w_is_end;
    logic                             w_encrypt;
    logic [hcs_pkg::CHAR_W-1:0]       w_char;
    hcs_pkg::t_lookup                 w_lookup;
    logic                             w_store;

    assign o_full    = i_job_full;
    assign w_accept  = i_push && !i_job_full;
    assign w_is_end  = (i_item.mode == hcs_pkg::MODE_END);
    assign w_encrypt = (i_direction == hcs_pkg::DIR_ENCRYPT);
    assign w_char    = w_encrypt ? hcs_pkg::fold_upper(i_item.data_char) : i_item.data_char;
    assign w_lookup  = hcs_pkg::char_to_index(w_char);
    assign w_store   = w_accept && !w_is_end && w_lookup.valid
                       && (r_count != CountW'(BufDepth));

    // Assemble the group: buffered entries, then the new index or space padding
    always_comb begin
        for (int c = 0; c < BufDepth; c++) begin
            if (CountW'(c) < r_count) begin
                o_job_idx[c*IdxW +: IdxW] = r_buf[c];
            end else begin
                o_job_idx[c*IdxW +: IdxW] = hcs_pkg::IDX_SPACE;
            end
        end
        o_job_idx[BufDepth*IdxW +: IdxW] = w_is_end ? hcs_pkg::IDX_SPACE : w_lookup.idx;
    end

    // Decide on a group request and the next fill count
    always_comb begin
        n_count            = r_count;
        o_job_push         = 1'b0;
        o_job_flags.dir    = i_direction;
        o_job_flags.at_end = w_is_end;
        if (w_accept) begin
            if (w_is_end) begin
                o_job_push = w_encrypt && (r_count != '0);
                n_count    = '0;
            end else if (w_lookup.valid) begin
                if (r_count == CountW'(BufDepth)) begin
                    o_job_push = 1'b1;
                    n_count    = '0;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    // Hold the partial group
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            for (int i = 0; i < BufDepth; i++) begin
                if (r_count == CountW'(i)) begin
                    r_buf[i] <= w_lookup.idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### hw/rtl/hcs_back.sv
`timescale 1ns / 1ps

// Back: one matrix row per cycle as queues allow; three-stage multiply, reduce and map
module hcs_back #(
    parameter int MatrixSize = hcs_pkg::MATRIX_SIZE_DEF,
    parameter int OutDepth   = hcs_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_job_empty,
    input  logic [MatrixSize*hcs_pkg::IDX_W-1:0]  i_job_idx,
    input  hcs_pkg::t_job_flags                   i_job_flags,
    output logic                                  o_job_pop,
    input  logic [hcs_pkg::KEY_W-1:0]             i_encrypt_key,
    input  logic [hcs_pkg::KEY_W-1:0]             i_decrypt_key,
    input  logic [$clog2(OutDepth+1)-1:0]         i_out_count,
    output logic                                  o_out_push,
    output hcs_pkg::t_out_item                    o_out_item
);

    localparam int RowW  = $clog2(MatrixSize);
    localparam int CntW  = $clog2(OutDepth + 1);
    localparam int RoomW = CntW + 1;
    localparam int IdxW  = hcs_pkg::IDX_W;
    localparam int AccW  = hcs_pkg::ACC_W;
    localparam int ProdW = hcs_pkg::ACC_W + hcs_pkg::RECIP_W;
    localparam int SelW  = hcs_pkg::KEY_SEL_W;

    logic [RowW-1:0]             r_row;
    logic                        w_room;
    logic                        w_issue;
    logic                        w_last_row;
    hcs_pkg::t_key               w_key;
    logic [AccW-1:0]             w_acc;
    hcs_pkg::t_row_flags         w_flags;

    logic                        r_s1_valid;
    logic [AccW-1:0]             r_s1_acc;
    hcs_pkg::t_row_flags         r_s1_flags;

    logic [ProdW-1:0]            w_prod;
    logic                        r_s2_valid;
    logic [AccW-1:0]             r_s2_acc;
    logic [hcs_pkg::QUO_W-1:0]   r_s2_quo;
    hcs_pkg::t_row_flags         r_s2_flags;

    logic [AccW-1:0]             w_rem;
    logic [AccW-1:0]             w_rem_fix;

    // Issue a row only while the result queue has room for it and all rows in flight
    assign w_room = (RoomW'(i_out_count) + RoomW'(r_s1_valid) + RoomW'(r_s2_valid))
                    < RoomW'(OutDepth);
    assign w_issue    = !i_job_empty && w_room;
    assign w_last_row = (r_row == RowW'(MatrixSize - 1));
    assign o_job_pop  = w_issue && w_last_row;
    assign w_key      = (i_job_flags.dir == hcs_pkg::DIR_DECRYPT) ? i_decrypt_key
                                                                  : i_encrypt_key;

    // Row dot product of key and group
    always_comb begin
        logic [SelW-1:0] sel;
        w_acc = '0;
        for (int c = 0; c < MatrixSize; c++) begin
            sel   = SelW'(int'(r_row) * MatrixSize + c);
            w_acc = w_acc + AccW'(w_key[sel]) * AccW'(i_job_idx[c*IdxW +: IdxW]);
        end
        w_flags.group_last  = w_last_row;
        w_flags.message_end = w_last_row && i_job_flags.at_end;
    end

    // Quotient estimate by reciprocal multiplication
    assign w_prod = ProdW'(r_s1_acc) * ProdW'(hcs_pkg::RECIP_MUL);

    // Remainder with one correction step
    always_comb begin
        w_rem     = r_s2_acc - AccW'(r_s2_quo) * AccW'(hcs_pkg::ALPHA_LEN);
        w_rem_fix = w_rem;
        if (w_rem >= AccW'(hcs_pkg::ALPHA_LEN)) begin
            w_rem_fix = w_rem - AccW'(hcs_pkg::ALPHA_LEN);
        end
    end

    assign o_out_push              = r_s2_valid;
    assign o_out_item.out_char     = hcs_pkg::index_to_char(IdxW'(w_rem_fix));
    assign o_out_item.group_last   = r_s2_flags.group_last;
    assign o_out_item.message_end  = r_s2_flags.message_end;

    // Advance the row counter and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_row <= w_last_row ? '0 : r_row + 1'b1;
            end
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_acc   <= w_acc;
        r_s1_flags <= w_flags;
        r_s2_acc   <= r_s1_acc;
        r_s2_quo   <= hcs_pkg::QUO_W'(w_prod >> hcs_pkg::RECIP_SHIFT);
        r_s2_flags <= r_s1_flags;
    end

endmodule

### hw/rtl/hill_cipher_stream_core.sv
`timescale 1ns / 1ps

// Hill cipher stream core.
// Input queue side: present a character or an end-of-message request on i_in_item
// and raise push; the request is taken at a clock edge where push is high and
// full is low. Result queue side: while empty is low, o_out_item holds the oldest
// result; raise pop to take it.
// Configuration: write direction, encrypt key or decrypt key through i_cfg_we,
// i_cfg_idx and i_cfg_wdata while no request is in progress.
// A request that completes a group passes the group queue, the back-end registers
// and result queue before its first result shows; the others follow one per cycle.
// Throughput: one request per cycle and one result per cycle, set by the back end
// computing one key row per cycle; an end request can release a whole group at once.
// A 2-entry group queue sits between front and back, a 4-entry result queue at
// the output.
// Reset clears the configuration, the partial group and both queues.
// When the receiver stalls, results collect in the result queue, then the back
// end stops, then the group queue fills and full rises.
module hill_cipher_stream_core #(
    parameter int MatrixSize = hcs_pkg::MATRIX_SIZE_DEF,
    parameter int JobDepth   = hcs_pkg::JOB_QUEUE_DEPTH,
    parameter int OutDepth   = hcs_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  hcs_pkg::t_in_item                 i_in_item,
    output logic                              empty,
    input  logic                              pop,
    output hcs_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [hcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hcs_pkg::KEY_W-1:0]         i_cfg_wdata
);

    localparam int GroupW = MatrixSize * hcs_pkg::IDX_W;
    localparam int FlagW  = $bits(hcs_pkg::t_job_flags);
    localparam int JobW   = GroupW + FlagW;
    localparam int OutW   = $bits(hcs_pkg::t_out_item);

    logic                          r_direction;
    logic [hcs_pkg::KEY_W-1:0]     r_encrypt_key;
    logic [hcs_pkg::KEY_W-1:0]     r_decrypt_key;

    logic                          w_job_push;
    logic [GroupW-1:0]             w_job_idx_in;
    hcs_pkg::t_job_flags           w_job_flags_in;
    logic                          w_job_full;
    logic                          w_job_empty;
    logic                          w_job_pop;
    logic [JobW-1:0]               w_job_rdata;

    logic                          w_out_push;
    hcs_pkg::t_out_item            w_out_item;
    logic [OutW-1:0]               w_out_rdata;
    logic [$clog2(OutDepth+1)-1:0] w_out_count;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction   <= hcs_pkg::DIR_ENCRYPT;
            r_encrypt_key <= '0;
            r_decrypt_key <= '0;
        end else if (i_cfg_we) begin
            case (hcs_pkg::t_cfg_idx'(i_cfg_idx))
                hcs_pkg::CFG_DIRECTION: begin
                    r_direction <= i_cfg_wdata[0];
                end
                hcs_pkg::CFG_ENCRYPT_KEY: begin
                    r_encrypt_key <= i_cfg_wdata;
                end
                hcs_pkg::CFG_DECRYPT_KEY: begin
                    r_decrypt_key <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    hcs_front #(
        .MatrixSize (MatrixSize)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_direction (r_direction),
        .i_job_full  (w_job_full),
        .o_full      (full),
        .o_job_push  (w_job_push),
        .o_job_idx   (w_job_idx_in),
        .o_job_flags (w_job_flags_in)
    );

    hcs_fifo #(
        .Width (JobW),
        .Depth (JobDepth)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_wdata ({w_job_flags_in, w_job_idx_in}),
        .i_pop   (w_job_pop),
        .o_rdata (w_job_rdata),
        .o_empty (w_job_empty),
        .o_full  (w_job_full),
        .o_count ()
    );

    hcs_back #(
        .MatrixSize (MatrixSize),
        .OutDepth   (OutDepth)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (w_job_empty),
        .i_job_idx     (w_job_rdata[GroupW-1:0]),
        .i_job_flags   (hcs_pkg::t_job_flags'(w_job_rdata[JobW-1:GroupW])),
        .o_job_pop     (w_job_pop),
        .i_encrypt_key (r_encrypt_key),
        .i_decrypt_key (r_decrypt_key),
        .i_out_count   (w_out_count),
        .o_out_push    (w_out_push),
        .o_out_item    (w_out_item)
    );

    hcs_fifo #(
        .Width (OutW),
        .Depth (OutDepth)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_wdata (w_out_item),
        .i_pop   (pop),
        .o_rdata (w_out_rdata),
        .o_empty (empty),
        .o_full  (),
        .o_count (w_out_count)
    );

    assign o_out_item = hcs_pkg::t_out_item'(w_out_rdata);

endmodule

### hw/rtl/hcs_checker.sv
`timescale 1ns / 1ps

module hcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input hcs_pkg::t_out_item o_out_item
);

    hcs_pkg::t_lookup w_out_lookup;

    // Look up the character on the result ports
    assign w_out_lookup = hcs_pkg::char_to_index(o_out_item.out_char);

    // Reset leaves both queues drained
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed before pop");

    // Message end only closes a group
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.message_end) |-> o_out_item.group_last)
        else $error("message end on a non-final group character");

    // Every result is an alphabet character
    a_char_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> w_out_lookup.valid)
        else $error("result character outside the alphabet");

endmodule

bind hill_cipher_stream_core hcs_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
